>>> hdl/hev_pkg.sv
package hev_pkg;

    // Command codes carried in the command field of a request word.
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_PLAY    = 3'd1;
    localparam logic [2:0] CMD_STOP    = 3'd2;
    localparam logic [2:0] CMD_WR_BYTE = 3'd3;
    localparam logic [2:0] CMD_SET_LEN = 3'd4;

    // Voice position advances by sixteen twenty-fifths of a window per tick.
    localparam logic [5:0] PHASE_STEP = 6'd16;
    localparam logic [5:0] PHASE_WRAP = 6'd25;
    localparam int unsigned DRIVE_MAX = 65535;

    // One request word.
    typedef struct packed {
        logic [2:0] command;
        logic [6:0] envelope_id;
        logic [1:0] motor_select;
        logic       loop_flag;
        logic [6:0] window_index;
        logic [7:0] amplitude_byte;
        logic [7:0] envelope_length;
    } req_word_t;

    // One result word.
    typedef struct packed {
        logic [15:0] left_drive;
        logic [15:0] right_drive;
        logic [4:0]  active_voices;
    } res_word_t;

    // Control passed from the voice walk to the mixing stage.
    typedef struct packed {
        logic       clear;
        logic       valid;
        logic [1:0] motor;
    } mix_ctl_t;

    typedef logic [255:0][15:0] drive_lut_t;

    // Builds the amplitude-to-drive table: 65535 * (30000 + 7 v^2) / 100000,
    // truncated and saturated at full scale.
    function automatic drive_lut_t drive_lut_build();
        drive_lut_t lut;
        longint unsigned num;
        for (int v = 0; v < 256; v++) begin
            num = 64'd30000 + 64'd7 * longint'(v) * longint'(v);
            if (num >= 64'd100000)
                lut[v] = 16'(DRIVE_MAX);
            else
                lut[v] = 16'((64'(DRIVE_MAX) * num) / 64'd100000);
        end
        return lut;
    endfunction

    localparam drive_lut_t DRIVE_LUT = drive_lut_build();

endpackage

>>> hdl/hev_ram.sv
module hev_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/hev_mix.sv
module hev_mix
    import hev_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mix_ctl_t    ctl,
    input  logic [7:0]  amp,
    output logic [15:0] left,
    output logic [15:0] right
);

    logic [15:0] drive;
    logic [15:0] left_reg;
    logic [15:0] right_reg;

    // Map the envelope byte to a drive level.
    assign drive = DRIVE_LUT[amp];

    // Running maximum per motor; the heavy motor skips buzz-only voices and
    // the buzz motor skips heavy-only voices.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
        end
        else if (ctl.clear)
        begin
            left_reg  <= '0;
            right_reg <= '0;
        end
        else if (ctl.valid)
        begin
            if (ctl.motor != 2'd1 && drive > left_reg)
            begin
                left_reg <= drive;
            end
            if (ctl.motor != 2'd0 && drive > right_reg)
            begin
                right_reg <= drive;
            end
        end
    end

    assign left  = left_reg;
    assign right = right_reg;

endmodule

>>> hdl/haptic_envelope_voice_mixer.sv
// A tick holds busy high while it walks the voices and strobes its result word in the same
// cycle that busy falls. A stop also holds busy high while it walks the voices. The voice
// walk reads one voice state entry per cycle through a
// four-stage pipeline (voice, length, byte, mix). Play, byte write and length write hold
// busy high for one cycle; other codes are taken with none. One request at a time.
// Reset clears the voice live bits and the length valid bits; the RAMs are not swept.
module haptic_envelope_voice_mixer
    import hev_pkg::*;
#(
    parameter int VOICES      = 24,
    parameter int ENVELOPES   = 128,
    parameter int MAX_WINDOWS = 128
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  req_word_t request,
    output logic      result_valid,
    output res_word_t result
);

    localparam int VOICE_AW   = VOICES > 1 ? $clog2(VOICES) : 1;
    localparam int VCNT_W     = $clog2(VOICES + 1);
    localparam int ENV_AW     = ENVELOPES > 1 ? $clog2(ENVELOPES) : 1;
    localparam int WIN_W      = $clog2(MAX_WINDOWS + 1);
    localparam int BYTE_DEPTH = ENVELOPES * MAX_WINDOWS;
    localparam int BYTE_AW    = BYTE_DEPTH > 1 ? $clog2(BYTE_DEPTH) : 1;
    localparam int VW         = 15 + WIN_W;
    localparam logic [8:0] ENV_LIMIT = 9'(ENVELOPES);
    localparam logic [8:0] WIN_LIMIT = 9'(MAX_WINDOWS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } state_t;

    // Control registers.
    state_t                 state_reg, state_next;
    req_word_t              req_reg, req_next;
    logic [VOICES-1:0]      live_reg, live_next;
    logic [ENVELOPES-1:0]   len_valid_reg, len_valid_next;
    logic [VCNT_W-1:0]      issue_reg, issue_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic [VOICE_AW-1:0]    s1_idx_reg, s1_idx_next;
    logic                   s2_valid_reg, s2_valid_next;
    logic [VOICE_AW-1:0]    s2_idx_reg, s2_idx_next;
    logic [VW-1:0]          s2_voice_reg, s2_voice_next;
    logic                   s2_len_ok_reg, s2_len_ok_next;
    mix_ctl_t               mix_ctl_reg, mix_ctl_next;
    logic [VCNT_W-1:0]      count_reg, count_next;
    logic                   res_valid_reg, res_valid_next;
    res_word_t              res_reg, res_next;

    // RAM ports.
    logic                   vram_we;
    logic [VOICE_AW-1:0]    vram_waddr, vram_raddr;
    logic [VW-1:0]          vram_wdata, vram_rdata;
    logic                   lram_we;
    logic [ENV_AW-1:0]      lram_waddr, lram_raddr;
    logic [WIN_W-1:0]       lram_wdata, lram_rdata;
    logic                   bram_we;
    logic [BYTE_AW-1:0]     bram_waddr, bram_raddr;
    logic [7:0]             bram_rdata;
    logic [15:0]            mix_left, mix_right;

    // Decoded request fields.
    logic                   env_ok;
    logic                   widx_ok;
    logic [ENV_AW-1:0]      req_env;
    logic [WIN_W-1:0]       req_len;
    logic                   free_found;
    logic [VOICE_AW-1:0]    free_idx;

    // Fields of the voice in the length stage.
    logic [6:0]             s1_env;
    logic                   s1_loop;

    // Fields of the voice in the update stage.
    logic [6:0]             v_env;
    logic [1:0]             v_motor;
    logic                   v_loop;
    logic [WIN_W-1:0]       v_win;
    logic [4:0]             v_phase;
    logic [WIN_W-1:0]       v_len;
    logic                   v_wrap;
    logic                   v_alive;
    logic [WIN_W-1:0]       w_use;
    logic [WIN_W-1:0]       w_new;
    logic [5:0]             ph_sum;
    logic [5:0]             ph_new;
    logic                   walk_done;
    logic [31:0]            count_wide;

    hev_ram #(.WIDTH(VW), .DEPTH(VOICES)) u_voice_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    hev_ram #(.WIDTH(WIN_W), .DEPTH(ENVELOPES)) u_len_ram (
        .clk   (clk),
        .we    (lram_we),
        .waddr (lram_waddr),
        .wdata (lram_wdata),
        .raddr (lram_raddr),
        .rdata (lram_rdata)
    );

    hev_ram #(.WIDTH(8), .DEPTH(BYTE_DEPTH)) u_byte_ram (
        .clk   (clk),
        .we    (bram_we),
        .waddr (bram_waddr),
        .wdata (req_reg.amplitude_byte),
        .raddr (bram_raddr),
        .rdata (bram_rdata)
    );

    hev_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mix_ctl_reg),
        .amp   (bram_rdata),
        .left  (mix_left),
        .right (mix_right)
    );

    // Request decode.
    always_comb
    begin
        env_ok  = {2'b00, req_reg.envelope_id} < ENV_LIMIT;
        widx_ok = {2'b00, req_reg.window_index} < WIN_LIMIT;
        req_env = ENV_AW'({2'b00, req_reg.envelope_id});
        if ({1'b0, req_reg.envelope_length} > WIN_LIMIT)
            req_len = WIN_W'(MAX_WINDOWS);
        else
            req_len = WIN_W'({1'b0, req_reg.envelope_length});
    end

    // Lowest free voice for play.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!live_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = VOICE_AW'(i);
            end
        end
    end

    // Voice word fields in the length stage and the update stage.
    always_comb
    begin
        s1_env  = vram_rdata[VW-1 -: 7];
        s1_loop = vram_rdata[WIN_W + 5];
        v_env   = s2_voice_reg[VW-1 -: 7];
        v_motor = s2_voice_reg[WIN_W + 7 -: 2];
        v_loop  = s2_voice_reg[WIN_W + 5];
        v_win   = s2_voice_reg[WIN_W + 4 -: WIN_W];
        v_phase = s2_voice_reg[4:0];
        v_len   = s2_len_ok_reg ? lram_rdata : '0;
    end

    // End or rewind at the envelope end, then advance the position.
    always_comb
    begin
        v_wrap  = v_win >= v_len;
        v_alive = live_reg[s2_idx_reg] && (!v_wrap || (v_loop && v_len != '0));
        w_use   = v_wrap ? '0 : v_win;
        ph_sum  = (v_wrap ? 6'd0 : {1'b0, v_phase}) + PHASE_STEP;
        if (ph_sum >= PHASE_WRAP)
        begin
            ph_new = ph_sum - PHASE_WRAP;
            w_new  = w_use + WIN_W'(1);
        end
        else
        begin
            ph_new = ph_sum;
            w_new  = w_use;
        end
    end

    assign walk_done  = (issue_reg == VCNT_W'(VOICES)) && !s1_valid_reg && !s2_valid_reg
                        && !mix_ctl_reg.valid;
    assign count_wide = 32'(count_reg);

    // Sequencer and voice walk pipeline.
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        live_next      = live_reg;
        len_valid_next = len_valid_reg;
        issue_next     = issue_reg;
        s1_valid_next  = 1'b0;
        s1_idx_next    = issue_reg[VOICE_AW-1:0];
        s2_valid_next  = 1'b0;
        s2_idx_next    = s1_idx_reg;
        s2_voice_next  = vram_rdata;
        s2_len_ok_next = len_valid_reg[ENV_AW'({2'b00, s1_env})];
        mix_ctl_next   = '0;
        mix_ctl_next.motor = v_motor;
        count_next     = count_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        vram_we    = 1'b0;
        vram_waddr = s2_idx_reg;
        vram_wdata = {v_env, v_motor, v_loop, w_new, ph_new[4:0]};
        vram_raddr = issue_reg[VOICE_AW-1:0];
        lram_we    = 1'b0;
        lram_waddr = req_env;
        lram_wdata = req_len;
        lram_raddr = ENV_AW'({2'b00, s1_env});
        bram_we    = 1'b0;
        bram_waddr = BYTE_AW'(req_env) * BYTE_AW'(MAX_WINDOWS)
                     + BYTE_AW'(req_reg.window_index);
        bram_raddr = BYTE_AW'(v_env) * BYTE_AW'(MAX_WINDOWS) + BYTE_AW'(w_use);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    issue_next = '0;
                    count_next = '0;
                    case (request.command)
                        CMD_TICK:
                        begin
                            mix_ctl_next.clear = 1'b1;
                            state_next = ST_WALK;
                        end
                        CMD_STOP:
                        begin
                            state_next = ST_WALK;
                        end
                        CMD_PLAY, CMD_WR_BYTE, CMD_SET_LEN:
                        begin
                            state_next = ST_EXEC;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (req_reg.command)
                    CMD_PLAY:
                    begin
                        if (env_ok && free_found)
                        begin
                            vram_we    = 1'b1;
                            vram_waddr = free_idx;
                            vram_wdata = {req_reg.envelope_id, req_reg.motor_select,
                                          req_reg.loop_flag, {WIN_W{1'b0}}, 5'd0};
                            live_next[free_idx] = 1'b1;
                        end
                    end
                    CMD_WR_BYTE:
                    begin
                        bram_we = env_ok && widx_ok;
                    end
                    CMD_SET_LEN:
                    begin
                        if (env_ok)
                        begin
                            lram_we = 1'b1;
                            len_valid_next[req_env] = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_WALK:
            begin
                // Issue one voice read per cycle.
                if (issue_reg != VCNT_W'(VOICES))
                begin
                    s1_valid_next = 1'b1;
                    issue_next    = issue_reg + VCNT_W'(1);
                end
                if (s1_valid_reg)
                begin
                    if (req_reg.command == CMD_STOP)
                    begin
                        if (live_reg[s1_idx_reg] && s1_env == req_reg.envelope_id && s1_loop)
                        begin
                            live_next[s1_idx_reg] = 1'b0;
                        end
                    end
                    else
                    begin
                        s2_valid_next = 1'b1;
                    end
                end
                // Update stage: end, rewind or advance, and hand the byte to the mixer.
                if (s2_valid_reg)
                begin
                    live_next[s2_idx_reg] = v_alive;
                    if (v_alive)
                    begin
                        vram_we            = 1'b1;
                        mix_ctl_next.valid = 1'b1;
                        count_next         = count_reg + VCNT_W'(1);
                    end
                end
                if (walk_done)
                begin
                    state_next = ST_IDLE;
                    if (req_reg.command == CMD_TICK)
                    begin
                        res_valid_next       = 1'b1;
                        res_next.left_drive  = mix_left;
                        res_next.right_drive = mix_right;
                        res_next.active_voices = (count_wide > 32'd31) ? 5'd31
                                                                       : count_wide[4:0];
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            live_reg      <= '0;
            len_valid_reg <= '0;
            issue_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            mix_ctl_reg   <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            len_valid_reg <= len_valid_next;
            issue_reg     <= issue_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            mix_ctl_reg   <= mix_ctl_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        s1_idx_reg    <= s1_idx_next;
        s2_idx_reg    <= s2_idx_next;
        s2_voice_reg  <= s2_voice_next;
        s2_len_ok_reg <= s2_len_ok_next;
        res_reg       <= res_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
